/* rtl/core/dtw_alignment_cost_defines.svh */
// Assertion macros shared by the dynamic time warping cost block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef DTW_ALIGNMENT_COST_DEFINES_SVH
`define DTW_ALIGNMENT_COST_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DAC_ASSERT_IMP(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Next-cycle implication, checked on every rising edge outside reset.
`define DAC_ASSERT_NXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

/* rtl/core/dac_pkg.sv */
// Shared types and constants of the dynamic time warping cost block.
// No dependencies; imported by every module of the block.
package dac_pkg;

  // Fixed field widths of the configuration registers and the row counter.
  localparam int ROWS_CFG_W = 17;
  localparam int COLS_CFG_W = 11;
  localparam int ROW_IDX_W  = 16;
  localparam int ROWS_LIMIT = 65536;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index, taken from the word address of the configuration port.
  typedef enum logic [0:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_idx_t;

  // Position of one cell inside the window.
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last;
  } cell_flags_t;

  // Window control from the register file to the sequencer.
  typedef struct packed {
    logic                 abort;
    logic [ROW_IDX_W-1:0] rows_last;
  } cfg_ctrl_t;

endpackage

/* rtl/core/dac_cfg.sv */
// Configuration registers (window rows and columns) behind an APB-style port.
// Depends on dac_pkg.
module dac_cfg import dac_pkg::*; #(
  parameter int COLS_MAX = 1024,
  localparam int ColW = $clog2(COLS_MAX)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_ctrl_t             ctrl,
  output logic [ColW-1:0]       cols_last
);

  logic [ROWS_CFG_W-1:0] num_rows_r;
  logic [COLS_CFG_W-1:0] num_cols_r;
  logic [ROW_IDX_W-1:0]  rows_last_r, rows_last_nxt;
  logic [ColW-1:0]       cols_last_r, cols_last_nxt;
  logic                  wr_en;
  reg_idx_t              wr_idx;
  logic [31:0]           rows_m1, cols_m1;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_idx = reg_idx_t'(paddr[2]);

  // Clamp the written value into range and keep it as the last index.
  always_comb begin
    rows_m1 = 32'(pwdata[ROWS_CFG_W-1:0]) - 32'd1;
    cols_m1 = 32'(pwdata[COLS_CFG_W-1:0]) - 32'd1;
    if (pwdata[ROWS_CFG_W-1:0] == '0) begin
      rows_last_nxt = '0;
    end else if (32'(pwdata[ROWS_CFG_W-1:0]) > 32'(ROWS_LIMIT)) begin
      rows_last_nxt = ROW_IDX_W'(ROWS_LIMIT - 1);
    end else begin
      rows_last_nxt = rows_m1[ROW_IDX_W-1:0];
    end
    if (pwdata[COLS_CFG_W-1:0] == '0) begin
      cols_last_nxt = '0;
    end else if (32'(pwdata[COLS_CFG_W-1:0]) > 32'(COLS_MAX)) begin
      cols_last_nxt = ColW'(COLS_MAX - 1);
    end else begin
      cols_last_nxt = cols_m1[ColW-1:0];
    end
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r  <= ROWS_CFG_W'(1);
      num_cols_r  <= COLS_CFG_W'(1);
      rows_last_r <= '0;
      cols_last_r <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_NUM_ROWS: begin
          num_rows_r  <= pwdata[ROWS_CFG_W-1:0];
          rows_last_r <= rows_last_nxt;
        end
        REG_NUM_COLS: begin
          num_cols_r  <= pwdata[COLS_CFG_W-1:0];
          cols_last_r <= cols_last_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  // Read back the raw register values.
  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_NUM_ROWS: prdata = APB_DATA_W'(num_rows_r);
      REG_NUM_COLS: prdata = APB_DATA_W'(num_cols_r);
      default:      prdata = '0;
    endcase
  end

  // Any write to a register starts a fresh window.
  assign ctrl.abort     = wr_en;
  assign ctrl.rows_last = rows_last_r;
  assign cols_last      = cols_last_r;

endmodule

/* rtl/core/dac_seq.sv */
// Row and column counters that place each accepted cell in the window.
// Depends on dac_pkg and the assertion macros header.
`include "dtw_alignment_cost_defines.svh"
module dac_seq import dac_pkg::*; #(
  parameter int COLS_MAX = 1024,
  localparam int ColW = $clog2(COLS_MAX)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  cfg_ctrl_t       ctrl,
  input  logic [ColW-1:0] cols_last,
  output logic [ColW-1:0] cell_col,
  output cell_flags_t     cell_flags
);

  logic [ColW-1:0]      col_r;
  logic [ROW_IDX_W-1:0] row_r;

  // Position of the cell offered in this cycle.
  always_comb begin
    cell_flags.first_row = (row_r == '0);
    cell_flags.first_col = (col_r == '0);
    cell_flags.last      = (col_r == cols_last) && (row_r == ctrl.rows_last);
  end
  assign cell_col = col_r;

  // Advance through the window in row-major order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (ctrl.abort) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (col_r == cols_last) begin
        col_r <= '0;
        row_r <= (row_r == ctrl.rows_last) ? '0 : row_r + ROW_IDX_W'(1);
      end else begin
        col_r <= col_r + ColW'(1);
      end
    end
  end

  `DAC_ASSERT_IMP(a_row_in_window, clk, rst_n, 1'b1, row_r <= ctrl.rows_last, "row beyond window")
  `DAC_ASSERT_IMP(a_col_in_window, clk, rst_n, 1'b1, col_r <= cols_last, "column beyond window")
  `DAC_ASSERT_NXT(a_last_wraps, clk, rst_n, accept && cell_flags.last && !ctrl.abort, (row_r == '0) && (col_r == '0), "window did not restart")

endmodule

/* rtl/core/dac_cell.sv */
// Cell stage: input register, row store, accumulate logic and result register.
// Depends on dac_pkg and the assertion macros header.
`include "dtw_alignment_cost_defines.svh"
module dac_cell import dac_pkg::*; #(
  parameter int COLS_MAX   = 1024,
  parameter int COST_WIDTH = 24,
  parameter int SUM_WIDTH  = 32,
  localparam int ColW = $clog2(COLS_MAX)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_accept,
  input  logic [COST_WIDTH-1:0] in_cost,
  input  logic [ColW-1:0]       in_col,
  input  cell_flags_t           in_flags,
  output logic                  hold,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [31:0]           out_total_cost,
  output logic                  out_saturated
);

  localparam int AW = ((SUM_WIDTH > COST_WIDTH) ? SUM_WIDTH : COST_WIDTH) + 1;
  localparam logic [SUM_WIDTH-1:0] SUM_INF = '1;

  logic [SUM_WIDTH-1:0]  row_store [COLS_MAX];

  logic                  s1_valid_r, s1_valid_nxt;
  logic [COST_WIDTH-1:0] cost_r;
  logic [ColW-1:0]       col_r;
  cell_flags_t           flags_r;
  logic [SUM_WIDTH-1:0]  rd_data_r, byp_data_r;
  logic                  byp_sel_r;
  logic [SUM_WIDTH-1:0]  left_r, diag_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           total_r;
  logic                  sat_r;

  logic                  advance;
  logic [SUM_WIDTH-1:0]  up, left, diag, best, acc;
  logic [AW-1:0]         sum;
  logic [63:0]           acc_ext;

  // A last cell waits while the result register still holds an untaken beat.
  assign hold    = s1_valid_r & flags_r.last & out_valid_r & out_stall;
  assign advance = s1_valid_r & ~hold;

  // Neighbors, with infinity outside the window and a zero corner.
  always_comb begin
    up = flags_r.first_row ? SUM_INF : (byp_sel_r ? byp_data_r : rd_data_r);
    if (flags_r.first_col) begin
      left = SUM_INF;
      diag = flags_r.first_row ? '0 : SUM_INF;
    end else begin
      left = left_r;
      diag = diag_r;
    end
  end

  // The saturating add is monotone, so add the cost once to the smallest neighbor.
  always_comb begin
    best = up;
    if (left < best) begin
      best = left;
    end
    if (diag < best) begin
      best = diag;
    end
    sum     = AW'(cost_r) + AW'(best);
    acc     = (sum > AW'(SUM_INF)) ? SUM_INF : sum[SUM_WIDTH-1:0];
    acc_ext = 64'(acc);
  end

  // Row store: write the finished cell, read the column of the next one.
  always_ff @(posedge clk) begin
    if (advance) begin
      row_store[col_r] <= acc;
    end
    if (in_accept) begin
      rd_data_r <= row_store[in_col];
    end
  end

  // Input register and forwarding of a same-column write in the same cycle.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cost_r     <= in_cost;
      col_r      <= in_col;
      flags_r    <= in_flags;
      byp_data_r <= acc;
    end
    if (advance) begin
      left_r <= acc;
      diag_r <= up;
    end
    if (advance && flags_r.last) begin
      total_r <= acc_ext[31:0];
      sat_r   <= (acc == SUM_INF);
    end
  end

  // Valid flags of the cell stage and the result register.
  always_comb begin
    s1_valid_nxt  = in_accept | hold;
    out_valid_nxt = out_valid_r & out_stall;
    if (advance && flags_r.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      byp_sel_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        byp_sel_r <= advance && (in_col == col_r);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_total_cost = total_r;
  assign out_saturated  = sat_r;

  `DAC_ASSERT_NXT(a_last_gives_result, clk, rst_n, advance && flags_r.last, out_valid_r, "last cell produced no result")
  `DAC_ASSERT_IMP(a_bypass_after_write, clk, rst_n, byp_sel_r && s1_valid_r && !$stable(col_r), $past(advance), "forwarding without a write")
  `DAC_ASSERT_NXT(a_hold_keeps_cell, clk, rst_n, hold, s1_valid_r && $stable(col_r) && $stable(flags_r), "held cell was lost")

endmodule

/* rtl/core/dtw_alignment_cost.sv */
// Top level of the dynamic time warping cost block.
// Depends on dac_pkg, dac_cfg, dac_seq and dac_cell.

// Takes the local costs of a num_rows by num_cols window one beat per cell in
// row-major order and returns one beat with the accumulated warping cost of
// the last cell; all-ones in total_cost means the path saturated. One cell is
// accepted every clock cycle unless the input stalls; the figure is set by the
// accumulate loop (minimum of three neighbors and one saturating add feeding
// the left-neighbor register), with the row store read into a register at
// accept time, at the column the counters already know. The last cell of the
// window passes the input register and then the result register, where the
// result is valid; while an earlier result still waits on the output, that
// last cell is held and the input stalls. The row store needs no clearing
// pass: the first row never reads it. Writing either register restarts the
// window and is only allowed while no cell is in flight.
module dtw_alignment_cost import dac_pkg::*; #(
  parameter int COLS_MAX   = 1024,
  parameter int COST_WIDTH = 24,
  parameter int SUM_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Cell input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COST_WIDTH-1:0] in_cost,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_total_cost,
  output logic                  out_saturated,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ColW = $clog2(COLS_MAX);

  cfg_ctrl_t         ctrl;
  logic [ColW-1:0]   cols_last;
  logic [ColW-1:0]   cell_col;
  cell_flags_t       cell_flags;
  logic              hold;
  logic              accept;

  // A beat is taken unless a finished last cell is waiting on the output.
  assign in_stall = hold;
  assign accept   = in_valid & ~hold;

  dac_cfg #(
    .COLS_MAX (COLS_MAX)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .ctrl      (ctrl),
    .cols_last (cols_last)
  );

  dac_seq #(
    .COLS_MAX (COLS_MAX)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .ctrl       (ctrl),
    .cols_last  (cols_last),
    .cell_col   (cell_col),
    .cell_flags (cell_flags)
  );

  dac_cell #(
    .COLS_MAX   (COLS_MAX),
    .COST_WIDTH (COST_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH)
  ) u_cell (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (accept),
    .in_cost        (in_cost),
    .in_col         (cell_col),
    .in_flags       (cell_flags),
    .hold           (hold),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_total_cost (out_total_cost),
    .out_saturated  (out_saturated)
  );

endmodule

/* verif/tb_dtw_alignment_cost.sv */
// Self-checking testbench for the dynamic time warping cost block.
// Depends on dac_pkg and dtw_alignment_cost; streams cost windows and checks
// each window total against an in-bench accumulator of the warping recurrence.
module tb_dtw_alignment_cost;
  timeunit 1ns;
  timeprecision 1ps;
  import dac_pkg::*;

  localparam int COLS_MAX    = 1024;
  localparam int COST_W      = 24;
  localparam int SUM_W       = 32;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int RAND_CELLS  = 120;
  localparam int LONG_HOLD   = 400;

  localparam logic [COST_W-1:0] COST_TOP = {COST_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_INF  = {SUM_W{1'b1}};

  // Flavors of local cost that a batch of cells is filled with.
  typedef enum int {COST_MIX, COST_MAX, COST_ZERO, COST_FULL} cost_kind_t;

  // One window total as the block should report it.
  typedef struct packed {
    logic [31:0] cost_sum;
    logic        clipped;
  } dtw_total_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COST_W-1:0]     in_cost = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [31:0]           out_total_cost;
  logic                  out_saturated;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Cells waiting to be sent and window totals waiting to come back.
  logic [COST_W-1:0] cost_backlog[$];
  dtw_total_t        totals_due[$];

  int   mismatches = 0;
  int   cycle_count = 0;
  logic cell_taken = 1'b0;

  // Accumulator state of the warping recurrence, mirrored in the bench.
  logic [SUM_W-1:0]      acc_row[COLS_MAX];
  logic [SUM_W-1:0]      left_acc = SUM_INF;
  logic [SUM_W-1:0]      diag_acc = '0;
  int unsigned           row_pos = 0;
  int unsigned           col_pos = 0;
  logic [ROWS_CFG_W-1:0] win_rows = 1;
  logic [COLS_CFG_W-1:0] win_cols = 1;

  dtw_alignment_cost #(
    .COLS_MAX  (COLS_MAX),
    .COST_WIDTH(COST_W),
    .SUM_WIDTH (SUM_W)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cost       (in_cost),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_total_cost(out_total_cost),
    .out_saturated (out_saturated),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Sum that clips to all-ones, which stands for infinity.
  function automatic logic [SUM_W-1:0] add_clip(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_INF : s[SUM_W-1:0];
  endfunction

  // A register write restarts the window at its first cell.
  function automatic void apply_window_reg(input reg_idx_t idx, input logic [31:0] data);
    case (idx)
      REG_NUM_ROWS: win_rows = data[ROWS_CFG_W-1:0];
      REG_NUM_COLS: win_cols = data[COLS_CFG_W-1:0];
      default: ;
    endcase
    row_pos  = 0;
    col_pos  = 0;
    left_acc = SUM_INF;
    diag_acc = '0;
  endfunction

  // Accumulates one cell; reports the total when the cell closes the window.
  function automatic void accumulate_cell(input logic [COST_W-1:0] cost,
                                          output bit window_done,
                                          output dtw_total_t result);
    int unsigned      rows_eff, cols_eff, c;
    logic [SUM_W-1:0] up, lft, dg, via_diag, via_left, via_up, acc;
    rows_eff = (win_rows == '0) ? 1 : (win_rows > ROWS_LIMIT) ? ROWS_LIMIT : win_rows;
    cols_eff = (win_cols == '0) ? 1 : (win_cols > COLS_MAX) ? COLS_MAX : win_cols;
    c = (col_pos >= cols_eff) ? 0 : col_pos;
    up = (row_pos == 0) ? SUM_INF : acc_row[c];
    // The first column sees infinity on the left; only the corner has a zero diagonal.
    if (c == 0) begin
      lft = SUM_INF;
      dg  = (row_pos == 0) ? '0 : SUM_INF;
    end else begin
      lft = left_acc;
      dg  = diag_acc;
    end
    via_diag = add_clip(SUM_W'(cost), dg);
    via_left = add_clip(SUM_W'(cost), lft);
    via_up   = add_clip(SUM_W'(cost), up);
    acc = via_diag;
    if (via_left < acc) acc = via_left;
    if (via_up < acc) acc = via_up;
    diag_acc   = up;
    left_acc   = acc;
    acc_row[c] = acc;
    window_done = 1'b0;
    result      = '0;
    if (c + 1 < cols_eff) begin
      col_pos = c + 1;
    end else begin
      col_pos = 0;
      if (row_pos + 1 < rows_eff) begin
        row_pos++;
      end else begin
        row_pos  = 0;
        left_acc = SUM_INF;
        diag_acc = '0;
        window_done     = 1'b1;
        result.cost_sum = acc;
        result.clipped  = (acc == SUM_INF);
      end
    end
  endfunction

  function automatic logic [COST_W-1:0] pick_cost(input cost_kind_t kind);
    case (kind)
      COST_MAX:  return COST_TOP;
      COST_ZERO: return '0;
      COST_FULL: return COST_W'($urandom());
      default: begin
        case ($urandom_range(0, 9))
          0:       return '0;
          1:       return COST_TOP;
          2:       return COST_W'($urandom_range(0, 255));
          default: return COST_W'($urandom());
        endcase
      end
    endcase
  endfunction

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic feed_cells(input int n, input cost_kind_t kind);
    @(posedge clk);
    repeat (n) cost_backlog.push_back(pick_cost(kind));
  endtask

  // Waits until every cell is sent and every total is back, then lets the
  // pipeline settle so that a partly fed window is no longer in flight.
  // The check runs at the rising edge, where the sender's beat is stable.
  task automatic wait_drained();
    do @(posedge clk);
    while (cost_backlog.size() != 0 || in_valid || totals_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Sender: bursts of beats with random gaps; a beat holds until taken.
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || cell_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (cost_backlog.size() != 0) begin
        in_valid <= 1'b1;
        in_cost  <= cost_backlog.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12)
                                                    : $urandom_range(0, 3);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus a long
  // hold-off on request so that the block backs up into its input.
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(10, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 1) == 0);
        2:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Monitor: tracks register writes and cell beats, checks result beats.
  always @(posedge clk) begin
    dtw_total_t due;
    bit         done;
    cell_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) apply_window_reg(reg_idx_t'(paddr[2]), pwdata);
      if (in_valid && !in_stall) begin
        accumulate_cell(in_cost, done, due);
        if (done) totals_due.push_back(due);
      end
      if (out_valid && !out_stall) begin
        if (totals_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, total_cost %h saturated %b",
                   $time, out_total_cost, out_saturated);
        end else begin
          due = totals_due.pop_front();
          if (out_total_cost !== due.cost_sum) begin
            mismatches++;
            $display("%0t: total_cost expected %h got %h",
                     $time, due.cost_sum, out_total_cost);
          end
          if (out_saturated !== due.clipped) begin
            mismatches++;
            $display("%0t: saturated expected %b got %b",
                     $time, due.clipped, out_saturated);
          end
        end
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("dtw_alignment_cost test failed");
    $finish;
  end

  initial begin
    int unsigned      rows_eff, cols_eff, span, n, random_cells;
    int               pick;
    logic [31:0]      rows_word, cols_word;
    logic [16:0]      rows_low;
    logic [10:0]      cols_low;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset window is one cell, so every beat gives a total.
    @(posedge clk);
    cost_backlog.push_back('0);
    cost_backlog.push_back(COST_TOP);
    cost_backlog.push_back(COST_W'(1));
    cost_backlog.push_back(COST_W'(24'h800000));
    wait_drained();

    // Two by three windows of all-max and all-zero cells.
    write_reg(REG_NUM_ROWS, 32'd2);
    write_reg(REG_NUM_COLS, 32'd3);
    feed_cells(6, COST_MAX);
    feed_cells(6, COST_ZERO);
    wait_drained();

    // Zero rows and columns act as one.
    write_reg(REG_NUM_COLS, 32'd0);
    write_reg(REG_NUM_ROWS, 32'd0);
    feed_cells(3, COST_MIX);
    wait_drained();

    // A register write in the middle of a window starts a fresh one.
    write_reg(REG_NUM_ROWS, 32'd4);
    write_reg(REG_NUM_COLS, 32'd4);
    feed_cells(7, COST_MIX);
    wait_drained();
    write_reg(REG_NUM_COLS, 32'd4);
    feed_cells(16, COST_MIX);
    wait_drained();

    // Column count above the store depth clamps; upper data bits are dropped.
    // A full-width single row of max costs saturates along the row.
    write_reg(REG_NUM_ROWS, 32'hFFFE_0001);
    write_reg(REG_NUM_COLS, 32'd2047);
    feed_cells(COLS_MAX, COST_MAX);
    wait_drained();

    // Column path landing exactly on all-ones.
    write_reg(REG_NUM_ROWS, 32'd257);
    write_reg(REG_NUM_COLS, 32'd1);
    feed_cells(256, COST_MAX);
    cost_backlog.push_back(COST_W'(255));
    wait_drained();

    // A row count above the limit clamps to it; the window is cut short.
    write_reg(REG_NUM_ROWS, 32'h0001_FFFF);
    feed_cells(20, COST_MIX);
    wait_drained();

    // One-cell windows with the receiver held off for a long stretch.
    write_reg(REG_NUM_ROWS, 32'd1);
    write_reg(REG_NUM_COLS, 32'd1);
    hold_req <= ~hold_req;
    feed_cells(40, COST_MIX);
    wait_drained();

    // Random small windows, sometimes cut short or continued across phases.
    rows_word = 32'd1;
    cols_word = 32'd1;
    random_cells = 0;
    while (random_cells < RAND_CELLS) begin
      wait_drained();
      pick = $urandom_range(0, 4);
      if (pick == 1 || pick >= 3) begin
        case ($urandom_range(0, 7))
          0:       rows_word = 32'd0;
          1:       rows_word = ($urandom() << ROWS_CFG_W) | $urandom_range(1, 6);
          default: rows_word = $urandom_range(1, 6);
        endcase
      end
      if (pick >= 2) begin
        case ($urandom_range(0, 7))
          0:       cols_word = 32'd0;
          1:       cols_word = ($urandom() << COLS_CFG_W) | $urandom_range(1, 8);
          2:       cols_word = $urandom_range(9, 40);
          default: cols_word = $urandom_range(1, 8);
        endcase
      end
      case (pick)
        1: write_reg(REG_NUM_ROWS, rows_word);
        2: write_reg(REG_NUM_COLS, cols_word);
        3: begin
          write_reg(REG_NUM_ROWS, rows_word);
          write_reg(REG_NUM_COLS, cols_word);
        end
        4: begin
          write_reg(REG_NUM_COLS, cols_word);
          write_reg(REG_NUM_ROWS, rows_word);
        end
        default: ;
      endcase
      rows_low = rows_word[16:0];
      cols_low = cols_word[10:0];
      rows_eff = (rows_low == 0) ? 1 : (rows_low > ROWS_LIMIT) ? ROWS_LIMIT : rows_low;
      cols_eff = (cols_low == 0) ? 1 : (cols_low > COLS_MAX) ? COLS_MAX : cols_low;
      span = rows_eff * cols_eff;
      n = $urandom_range(1, 4) * span;
      if (span > 1 && $urandom_range(0, 3) == 0) n += $urandom_range(1, span - 1);
      // The last batch is trimmed so the phase stays near its cell budget.
      if (n > RAND_CELLS - random_cells) n = RAND_CELLS - random_cells;
      feed_cells(n, COST_MIX);
      random_cells += n;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("dtw_alignment_cost test passed");
    end else begin
      $display("dtw_alignment_cost test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/dac_pkg.sv
rtl/core/dac_cfg.sv
rtl/core/dac_seq.sv
rtl/core/dac_cell.sv
rtl/core/dtw_alignment_cost.sv
verif/tb_dtw_alignment_cost.sv
